>>> design/substring_find_replace_assert.svh
// Assertion helpers for the substring find/replace block.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is held.
`ifndef SUBSTRING_FIND_REPLACE_ASSERT_SVH
`define SUBSTRING_FIND_REPLACE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

>>> design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, register indexes and helpers for the find/replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIND_PATTERN    = 3'd0,
        REG_FIND_LENGTH     = 3'd1,
        REG_REPLACE_PATTERN = 3'd2,
        REG_REPLACE_LENGTH  = 3'd3
    } reg_index_t;

    typedef struct packed {
        logic [63:0] find_pattern;
        logic [3:0]  find_length;
        logic [63:0] replace_pattern;
        logic [3:0]  replace_length;
    } sfr_cfg_t;

    // control handed from the window logic to the result buffer
    typedef struct packed {
        logic load;     // an item was accepted this cycle
        logic last;     // the burst closes the string
        logic marker;   // the burst is a bare end marker
    } sfr_load_t;

    // byte idx of a packed little-endian word; zero beyond bit 63
    function automatic logic [7:0] pick_byte(input logic [63:0] word, input int idx);
        logic [63:0] sh;
        sh = word >> (8 * idx);
        return sh[7:0];
    endfunction

endpackage

>>> design/substring_find_replace.sv
// ----------------------------------------------------------------------------
// substring_find_replace
// Streaming find-and-replace over a byte string with end-of-string marks.
// ----------------------------------------------------------------------------
// Each accepted byte is folded into a window of up to MAX_FIND_LEN pending
// bytes; the results it causes (drained bytes, the replacement, the end
// flush, or one bare end marker with byte_valid low) load a burst buffer
// that hands one result per cycle to the output register unless m_ready
// stalls it. Plain text, where each byte causes zero or one result, streams
// at one byte per clock while m_ready does not stall; a byte that causes k
// results holds s_ready low while the burst buffer empties, up to
// max(MAX_FIND_LEN, MAX_REPLACE_LEN) results. Lengths above the parameters
// are clamped; a find length of zero passes bytes through. Configuration
// must be written only while the block is idle; the block does not enforce it.
module substring_find_replace #(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_last_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_byte_valid,
    output logic                           m_last_out
);
    import sfr_pkg::*;

    localparam int NB = (MAX_FIND_LEN > MAX_REPLACE_LEN) ? MAX_FIND_LEN : MAX_REPLACE_LEN;
    localparam int CW = $clog2(NB + 1);

    sfr_cfg_t      cfg;
    sfr_load_t     load;
    logic [7:0]    load_bytes [NB];
    logic [CW-1:0] load_cnt;
    logic          can_accept;
    logic          accept;

    assign s_ready = can_accept;
    assign accept  = s_valid && can_accept;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfr_window #(
        .MAX_FIND_LEN    (MAX_FIND_LEN),
        .MAX_REPLACE_LEN (MAX_REPLACE_LEN),
        .NB              (NB),
        .CW              (CW)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .last_in    (s_last_in),
        .cfg        (cfg),
        .load       (load),
        .load_bytes (load_bytes),
        .load_cnt   (load_cnt)
    );

    sfr_out_buf #(
        .DEPTH (NB),
        .CW    (CW)
    ) u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .load_bytes   (load_bytes),
        .load_cnt     (load_cnt),
        .can_accept   (can_accept),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last_out   (m_last_out)
    );

endmodule

>>> design/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file: find/replace patterns and their lengths.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output sfr_pkg::sfr_cfg_t             cfg
);
    import sfr_pkg::*;

    sfr_cfg_t cfg_reg;
    sfr_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_FIND_PATTERN:    cfg_next.find_pattern    = cfg_wdata;
                REG_FIND_LENGTH:     cfg_next.find_length     = cfg_wdata[3:0];
                REG_REPLACE_PATTERN: cfg_next.replace_pattern = cfg_wdata;
                REG_REPLACE_LENGTH:  cfg_next.replace_length  = cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window
// Pending-byte window and the single-pass step: append, match, drain, flush.
// Produces the full result burst for one accepted beat.
// ----------------------------------------------------------------------------
module sfr_window #(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8,
    parameter int NB              = 8,
    parameter int CW              = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_in,
    input  sfr_pkg::sfr_cfg_t  cfg,
    output sfr_pkg::sfr_load_t load,
    output logic [7:0]         load_bytes [NB],
    output logic [CW-1:0]      load_cnt
);
    import sfr_pkg::*;

    localparam int FLW = $clog2(MAX_FIND_LEN + 1);
    localparam int RLW = $clog2(MAX_REPLACE_LEN + 1);
    localparam int AW  = (MAX_FIND_LEN > 1) ? $clog2(MAX_FIND_LEN) : 1;

    logic [7:0]     win_reg  [MAX_FIND_LEN];
    logic [7:0]     win_next [MAX_FIND_LEN];
    logic [FLW-1:0] pc_reg, pc_next;

    logic [7:0]     win [MAX_FIND_LEN];
    logic [FLW-1:0] flen, pc_inc, drain;
    logic [RLW-1:0] rlen;
    logic           match;
    logic           marker;
    logic [CW-1:0]  cnt;

    always_comb begin
        int idx;
        flen = (32'(cfg.find_length) > MAX_FIND_LEN) ? FLW'(MAX_FIND_LEN)
                                                     : FLW'(cfg.find_length);
        rlen = (32'(cfg.replace_length) > MAX_REPLACE_LEN) ? RLW'(MAX_REPLACE_LEN)
                                                           : RLW'(cfg.replace_length);
        pc_inc = pc_reg + 1'b1;

        // window with the new byte appended
        for (int i = 0; i < MAX_FIND_LEN; i++) begin
            win[i] = (FLW'(i) == pc_reg) ? data_byte : win_reg[i];
        end

        // match only when the window holds exactly find_length bytes
        match = (flen != '0) && (pc_inc == flen);
        for (int i = 0; i < MAX_FIND_LEN; i++) begin
            if ((FLW'(i) < flen) && (win[i] != pick_byte(cfg.find_pattern, i))) begin
                match = 1'b0;
            end
        end

        // bytes leaving the front on a miss
        if (flen == '0) begin
            drain = pc_inc;
        end else if (pc_inc >= flen) begin
            drain = pc_inc - flen + 1'b1;
        end else begin
            drain = '0;
        end

        // drain plus end flush covers the whole window
        if (match) begin
            cnt = CW'(rlen);
        end else if (last_in) begin
            cnt = CW'(pc_inc);
        end else begin
            cnt = CW'(drain);
        end
        marker = last_in && (cnt == '0);
        if (marker) begin
            cnt = CW'(1);
        end

        for (int i = 0; i < NB; i++) begin
            if (match) begin
                load_bytes[i] = pick_byte(cfg.replace_pattern, i);
            end else if (i < MAX_FIND_LEN) begin
                load_bytes[i] = win[i];
            end else begin
                load_bytes[i] = 8'h00;
            end
        end

        pc_next = (match || last_in) ? '0 : (pc_inc - drain);

        for (int i = 0; i < MAX_FIND_LEN; i++) begin
            idx = i + int'(drain);
            win_next[i] = (idx < MAX_FIND_LEN) ? win[AW'(idx)] : win[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else if (accept) begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

    assign load.load   = accept;
    assign load.last   = last_in;
    assign load.marker = marker;
    assign load_cnt    = cnt;

endmodule

>>> design/sfr_out_buf.sv
// ----------------------------------------------------------------------------
// sfr_out_buf
// Result burst buffer feeding a registered output beat. The buffer shifts
// one result per cycle into the output register unless m_ready stalls it.
// ----------------------------------------------------------------------------
module sfr_out_buf #(
    parameter int DEPTH = 8,
    parameter int CW    = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sfr_pkg::sfr_load_t load,
    input  logic [7:0]         load_bytes [DEPTH],
    input  logic [CW-1:0]      load_cnt,
    output logic               can_accept,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_last_out
);
    import sfr_pkg::*;

    logic [7:0]    buf_reg [DEPTH];
    logic [7:0]    buf_next [DEPTH];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          marker_reg, marker_next;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_bvalid_reg, m_bvalid_next;
    logic          m_last_reg, m_last_next;

    logic          advance;

    assign advance    = (cnt_reg != '0) && (!m_valid_reg || m_ready);
    // free when empty or once the final buffered result moves out this cycle
    assign can_accept = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && advance);

    always_comb begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        marker_next = marker_reg;
        if (load.load) begin
            buf_next    = load_bytes;
            cnt_next    = load_cnt;
            last_next   = load.last;
            marker_next = load.marker;
        end else if (advance) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_bvalid_next = m_bvalid_reg;
        m_last_next   = m_last_reg;
        if (advance) begin
            m_valid_next  = 1'b1;
            m_byte_next   = marker_reg ? 8'h00 : buf_reg[0];
            m_bvalid_next = !marker_reg;
            m_last_next   = last_reg && (cnt_reg == CW'(1));
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg      <= buf_next;
        last_reg     <= last_next;
        marker_reg   <= marker_next;
        m_byte_reg   <= m_byte_next;
        m_bvalid_reg <= m_bvalid_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_byte_valid = m_bvalid_reg;
    assign m_last_out   = m_last_reg;

endmodule

>>> design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result channel of substring_find_replace.
// ----------------------------------------------------------------------------
`include "substring_find_replace_assert.svh"

module sfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_last_out
);

    // stalled beat holds
    `SFR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_byte_valid) && $stable(m_last_out))

    // a bare end marker only ever closes a string
    `SFR_ASSERT_IMP(a_marker_last, aclk, aresetn, m_valid && !m_byte_valid, m_last_out)

    // a bare end marker carries a zero byte
    `SFR_ASSERT_IMP(a_marker_zero, aclk, aresetn, m_valid && !m_byte_valid, m_out_byte == 8'h00)

endmodule

bind substring_find_replace sfr_checker u_sfr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_last_out   (m_last_out)
);
